[hdl/bhg_pkg.sv]
// ---------------------------------------------------------------------------
// bhg_pkg: shared types and constants for the box heat map gradient block
// Command and register codes, the stored box layout, sequencer states and
// the control group of the shared arithmetic unit.
// ---------------------------------------------------------------------------
package bhg_pkg;

	// default box store depth
	localparam int MAX_BOXES_DEF = 16;
	// heat maps at or above this label never take the weighted case
	localparam int MAX_MAPS = 64;

	// field widths
	localparam int CW   = 11;	// scaled coordinate
	localparam int LW   = 6;	// class label
	localparam int RW   = 10;	// pixel row / column
	localparam int XW   = 16;	// raw box coordinate
	localparam int PW   = 32;	// prediction / gradient
	localparam int OSW  = 11;	// output_size
	localparam int ISW  = 13;	// input_size
	localparam int NWW  = 17;	// neg_weight
	localparam int MAW  = 18;	// multiplier A operand
	localparam int PRW  = MAW + PW;	// product

	// commands (s_tuser)
	localparam logic [1:0] CMD_CLEAR = 2'd0;
	localparam logic [1:0] CMD_ADD   = 2'd1;
	localparam logic [1:0] CMD_QUERY = 2'd2;

	// configuration register indexes
	localparam logic [1:0] REG_OUTPUT_SIZE = 2'd0;
	localparam logic [1:0] REG_INPUT_SIZE  = 2'd1;
	localparam logic [1:0] REG_OTHER_NEG   = 2'd2;
	localparam logic [1:0] REG_NEG_WEIGHT  = 2'd3;

	// configuration reset values
	localparam logic [OSW-1:0] OUTPUT_SIZE_RST = 11'd32;
	localparam logic [ISW-1:0] INPUT_SIZE_RST  = 13'd224;
	localparam logic [NWW-1:0] NEG_WEIGHT_RST  = 17'd65536;

	// Q16.16 constants
	localparam logic signed [PW:0]   ONE_Q16 = 33'sd65536;
	localparam logic signed [PW-1:0] SAT_MAX = 32'sh7fff_ffff;
	localparam logic signed [PW-1:0] SAT_MIN = 32'sh8000_0000;

	// one stored box, coordinates already scaled to the heat map
	typedef struct packed {
		logic [CW-1:0] xmin;
		logic [CW-1:0] ymin;
		logic [CW-1:0] xmax;
		logic [CW-1:0] ymax;
		logic [LW-1:0] label;
		logic          neg;
	} box_t;

	// what the last matching box decided
	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_PASS,
		KIND_WEIGHT
	} kind_t;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SMUL,
		ST_SLOAD,
		ST_SDIV,
		ST_SSAVE,
		ST_SWRITE,
		ST_SCAN,
		ST_WMUL,
		ST_EMIT
	} state_t;

	// control group of the shared arithmetic unit
	typedef struct packed {
		logic mul_en;
		logic div_load;
		logic div_step;
	} alu_ctl_t;

endpackage

[hdl/bhg_arith.sv]
// ---------------------------------------------------------------------------
// bhg_arith: shared multiplier and radix-2 divider step
// One registered multiplier serves both coordinate scaling and the weighted
// gradient; a restoring divider takes the scaled product apart one quotient
// bit per cycle.
// ---------------------------------------------------------------------------
module bhg_arith (
	input  logic                              clk,
	input  bhg_pkg::alu_ctl_t                 ctl,
	input  logic signed [bhg_pkg::MAW-1:0]    mul_a,
	input  logic signed [bhg_pkg::PW-1:0]     mul_b,
	input  logic        [bhg_pkg::ISW-1:0]    den,
	output logic signed [bhg_pkg::PRW-1:0]    prod,
	output logic        [bhg_pkg::CW-1:0]     quot,
	output logic                              num_pos,
	output logic                              num_big
);

	logic signed [bhg_pkg::PRW-1:0] prod_q;
	logic [bhg_pkg::ISW-1:0]        rem_q;
	logic [bhg_pkg::CW-1:0]         nlo_q;
	logic [bhg_pkg::CW-1:0]         quot_q;
	logic [bhg_pkg::ISW:0]          trial;
	logic                           fits;

	// numerator is prod_q; high part above the quotient bits must be < den
	assign num_pos = !prod_q[bhg_pkg::PRW-1] && (prod_q != '0);
	assign num_big = ({2'b00, prod_q[25:11]} >= {4'b0000, den});

	// one restoring step
	assign trial = {rem_q, nlo_q[bhg_pkg::CW-1]};
	assign fits  = (trial >= {1'b0, den});

	always_ff @(posedge clk) begin
		if (ctl.mul_en) begin
			prod_q <= mul_a * mul_b;
		end
		if (ctl.div_load) begin
			rem_q  <= prod_q[23:11];
			nlo_q  <= prod_q[10:0];
			quot_q <= '0;
		end else if (ctl.div_step) begin
			rem_q  <= fits ? bhg_pkg::ISW'(trial - {1'b0, den}) : trial[bhg_pkg::ISW-1:0];
			nlo_q  <= {nlo_q[bhg_pkg::CW-2:0], 1'b0};
			quot_q <= {quot_q[bhg_pkg::CW-2:0], fits};
		end
	end

	assign prod = prod_q;
	assign quot = quot_q;

endmodule

[hdl/box_heatmap_gradient.sv]
// ---------------------------------------------------------------------------
// box_heatmap_gradient: heat map loss gradients from bounding boxes
// Stores scaled boxes of one image and answers pixel queries with a
// saturated Q16.16 gradient.
// ---------------------------------------------------------------------------
// Usage
//   s_* carries commands: s_tuser selects clear, add box or pixel query.
//   Clear and add give no result beat; each query gives exactly one beat on
//   m_* (gradient in m_tdata, the box overflow flag in m_tuser).
//   cfg_* writes the four setup registers; write them only while idle.
// Sequence
//   Clear finishes in the accepting cycle. Add: the accepting cycle, then four
//   coordinates each through one multiply and an 11-step divide on the
//   shared arithmetic unit, then the store write; an add to a full store only
//   sets the overflow flag. Query: one box compare per cycle from the single
//   read port of the box store, then the weighted multiply and the result
//   load. A pixel outside the map skips the scan.
//   s_tready is high only while the sequencer is idle.
// Reset and stall
//   Reset empties the store and loads the register defaults; store
//   contents are not cleared, only the count. A stalled m_* holds its beat;
//   the next query finishes and waits until the output register is free.
// ---------------------------------------------------------------------------
module box_heatmap_gradient #(
	parameter int MAX_BOXES = bhg_pkg::MAX_BOXES_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	// configuration writes
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic [16:0]  cfg_data,
	// command stream
	input  logic         s_tvalid,
	output logic         s_tready,
	// box_xmin, box_ymin, box_xmax, box_ymax, box_label, box_negative,
	// map_label, pixel_row, pixel_col, prediction, 7 zero pad bits
	input  logic [135:0] s_tdata,
	// cmd
	input  logic [1:0]   s_tuser,
	// result stream
	output logic         m_tvalid,
	input  logic         m_tready,
	// gradient
	output logic [31:0]  m_tdata,
	// box_overflow
	output logic [0:0]   m_tuser
);

	localparam int CNTW = $clog2(MAX_BOXES + 1);
	localparam int IW   = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;

	// configuration registers
	logic [bhg_pkg::OSW-1:0] out_size_q;
	logic [bhg_pkg::ISW-1:0] in_size_q;
	logic                    oan_q;
	logic [bhg_pkg::NWW-1:0] nw_q;

	bhg_pkg::state_t state_q, state_d;

	logic [CNTW-1:0]           count_q;
	logic                      ovf_q;
	logic [bhg_pkg::XW-1:0]    coord_q [4];
	logic [bhg_pkg::CW-1:0]    sc_q [4];
	logic [bhg_pkg::LW-1:0]    label_q;
	logic                      neg_q;
	logic [1:0]                cidx_q;
	logic [3:0]                step_q;
	logic [bhg_pkg::LW-1:0]    map_q;
	logic [bhg_pkg::RW-1:0]    row_q;
	logic [bhg_pkg::RW-1:0]    col_q;
	logic signed [bhg_pkg::PW-1:0] pred_q;
	logic [CNTW-1:0]           scan_q;
	logic                      inside_q;
	bhg_pkg::kind_t            kind_q;

	bhg_pkg::box_t             mem_q [MAX_BOXES];
	bhg_pkg::box_t             rd_q;
	bhg_pkg::box_t             wr_box;

	logic                      m_valid_q;
	logic [bhg_pkg::PW-1:0]    grad_q;
	logic                      ovf_out_q;

	// input field views
	logic [bhg_pkg::LW-1:0]    in_label;
	logic                      in_neg;
	logic [bhg_pkg::LW-1:0]    in_map;
	logic [bhg_pkg::RW-1:0]    in_row;
	logic [bhg_pkg::RW-1:0]    in_col;
	logic [bhg_pkg::PW-1:0]    in_pred;
	logic                      s_acc;
	logic                      full;
	logic                      in_map_area;

	// arithmetic unit hookup
	bhg_pkg::alu_ctl_t                 alu_ctl;
	logic signed [bhg_pkg::MAW-1:0]    mul_a;
	logic signed [bhg_pkg::PW-1:0]     mul_b;
	logic        [bhg_pkg::ISW-1:0]    den;
	logic signed [bhg_pkg::PRW-1:0]    prod;
	logic        [bhg_pkg::CW-1:0]     quot;
	logic                              num_pos;
	logic                              num_big;

	logic                      mem_we;
	logic                      out_load;
	logic [bhg_pkg::CW-1:0]    scaled;
	logic [bhg_pkg::XW-1:0]    cur_coord;

	// box compare
	logic                      holds;
	logic                      label_eq;
	logic                      map_ok;
	logic                      inside_d;
	bhg_pkg::kind_t            kind_d;

	// gradient select
	logic signed [bhg_pkg::PW:0]   dec;
	logic signed [33:0]            wq;
	logic [bhg_pkg::PW-1:0]        grad;

	assign in_label = s_tdata[69:64];
	assign in_neg   = s_tdata[70];
	assign in_map   = s_tdata[76:71];
	assign in_row   = s_tdata[86:77];
	assign in_col   = s_tdata[96:87];
	assign in_pred  = s_tdata[128:97];

	assign s_acc       = s_tvalid && s_tready;
	assign full        = (count_q >= CNTW'(MAX_BOXES));
	assign in_map_area = ({1'b0, in_row} < out_size_q) && ({1'b0, in_col} < out_size_q);

	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_size_q <= bhg_pkg::OUTPUT_SIZE_RST;
			in_size_q  <= bhg_pkg::INPUT_SIZE_RST;
			oan_q      <= 1'b0;
			nw_q       <= bhg_pkg::NEG_WEIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bhg_pkg::REG_OUTPUT_SIZE: out_size_q <= cfg_data[bhg_pkg::OSW-1:0];
				bhg_pkg::REG_INPUT_SIZE:  in_size_q  <= cfg_data[bhg_pkg::ISW-1:0];
				bhg_pkg::REG_OTHER_NEG:   oan_q      <= cfg_data[0];
				bhg_pkg::REG_NEG_WEIGHT:  nw_q       <= cfg_data;
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bhg_pkg::ST_IDLE: begin
				if (s_acc) begin
					if (s_tuser == bhg_pkg::CMD_ADD && !full) begin
						state_d = bhg_pkg::ST_SMUL;
					end else if (s_tuser == bhg_pkg::CMD_QUERY) begin
						state_d = in_map_area ? bhg_pkg::ST_SCAN : bhg_pkg::ST_WMUL;
					end
				end
			end
			bhg_pkg::ST_SMUL:  state_d = bhg_pkg::ST_SLOAD;
			bhg_pkg::ST_SLOAD: state_d = bhg_pkg::ST_SDIV;
			bhg_pkg::ST_SDIV: begin
				if (step_q == 4'(bhg_pkg::CW - 1)) state_d = bhg_pkg::ST_SSAVE;
			end
			bhg_pkg::ST_SSAVE: begin
				state_d = (cidx_q == 2'd3) ? bhg_pkg::ST_SWRITE : bhg_pkg::ST_SMUL;
			end
			bhg_pkg::ST_SWRITE: state_d = bhg_pkg::ST_IDLE;
			bhg_pkg::ST_SCAN: begin
				if (scan_q == count_q) state_d = bhg_pkg::ST_WMUL;
			end
			bhg_pkg::ST_WMUL: state_d = bhg_pkg::ST_EMIT;
			bhg_pkg::ST_EMIT: begin
				if (!m_valid_q || m_tready) state_d = bhg_pkg::ST_IDLE;
			end
			default: state_d = bhg_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready         = 1'b0;
		alu_ctl          = '0;
		mem_we           = 1'b0;
		out_load         = 1'b0;
		case (state_q)
			bhg_pkg::ST_IDLE:   s_tready         = 1'b1;
			bhg_pkg::ST_SMUL:   alu_ctl.mul_en   = 1'b1;
			bhg_pkg::ST_SLOAD:  alu_ctl.div_load = 1'b1;
			bhg_pkg::ST_SDIV:   alu_ctl.div_step = 1'b1;
			bhg_pkg::ST_SWRITE: mem_we           = 1'b1;
			bhg_pkg::ST_WMUL:   alu_ctl.mul_en   = 1'b1;
			bhg_pkg::ST_EMIT:   out_load         = !m_valid_q || m_tready;
			default: ;
		endcase
	end

	// operand select for the shared multiplier
	assign cur_coord = coord_q[cidx_q];
	assign mul_a = (state_q == bhg_pkg::ST_WMUL) ? $signed({1'b0, nw_q})
		: $signed({7'b0, out_size_q});
	assign mul_b = (state_q == bhg_pkg::ST_WMUL) ? pred_q
		: $signed({{16{cur_coord[bhg_pkg::XW-1]}}, cur_coord});
	assign den   = (in_size_q == '0) ? bhg_pkg::ISW'(1) : in_size_q;

	bhg_arith u_arith (
		.clk     (clk),
		.ctl     (alu_ctl),
		.mul_a   (mul_a),
		.mul_b   (mul_b),
		.den     (den),
		.prod    (prod),
		.quot    (quot),
		.num_pos (num_pos),
		.num_big (num_big)
	);

	// floor(x*out/in) clamped to [0, out]
	always_comb begin
		if (!num_pos) begin
			scaled = '0;
		end else if (num_big || quot > out_size_q) begin
			scaled = out_size_q;
		end else begin
			scaled = quot;
		end
	end

	// one stored box against the queried pixel
	assign holds = ({1'b0, col_q} >= rd_q.xmin) && ({1'b0, col_q} < rd_q.xmax)
		&& ({1'b0, row_q} >= rd_q.ymin) && ({1'b0, row_q} < rd_q.ymax);
	assign label_eq = (rd_q.label == map_q);
	assign map_ok   = (int'(map_q) < bhg_pkg::MAX_MAPS);

	always_comb begin
		inside_d = inside_q;
		kind_d   = kind_q;
		if (scan_q != '0) begin
			if (rd_q.neg) begin
				if (label_eq) kind_d = bhg_pkg::KIND_PASS;
			end else begin
				if (label_eq && holds) inside_d = 1'b1;
				if (oan_q) begin
					if (label_eq) begin
						kind_d = bhg_pkg::KIND_PASS;
					end else if (holds && map_ok) begin
						kind_d = bhg_pkg::KIND_WEIGHT;
					end
				end
			end
		end
	end

	// sequencer and working registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= bhg_pkg::ST_IDLE;
			count_q  <= '0;
			ovf_q    <= 1'b0;
			cidx_q   <= '0;
			step_q   <= '0;
			scan_q   <= '0;
			inside_q <= 1'b0;
			kind_q   <= bhg_pkg::KIND_NONE;
		end else begin
			state_q <= state_d;
			case (state_q)
				bhg_pkg::ST_IDLE: begin
					if (s_acc) begin
						if (s_tuser == bhg_pkg::CMD_CLEAR) begin
							count_q <= '0;
							ovf_q   <= 1'b0;
						end else if (s_tuser == bhg_pkg::CMD_ADD) begin
							if (full) ovf_q <= 1'b1;
							cidx_q <= '0;
						end else if (s_tuser == bhg_pkg::CMD_QUERY) begin
							scan_q   <= '0;
							inside_q <= 1'b0;
							kind_q   <= bhg_pkg::KIND_NONE;
						end
					end
				end
				bhg_pkg::ST_SLOAD: step_q <= '0;
				bhg_pkg::ST_SDIV:  step_q <= step_q + 4'd1;
				bhg_pkg::ST_SSAVE: cidx_q <= cidx_q + 2'd1;
				bhg_pkg::ST_SWRITE: count_q <= count_q + CNTW'(1);
				bhg_pkg::ST_SCAN: begin
					inside_q <= inside_d;
					kind_q   <= kind_d;
					if (scan_q != count_q) scan_q <= scan_q + CNTW'(1);
				end
				default: ;
			endcase
		end
	end

	// item payload capture and scaled coordinates
	always_ff @(posedge clk) begin
		if (s_acc) begin
			coord_q[0] <= s_tdata[15:0];
			coord_q[1] <= s_tdata[31:16];
			coord_q[2] <= s_tdata[47:32];
			coord_q[3] <= s_tdata[63:48];
			label_q    <= in_label;
			neg_q      <= in_neg;
			map_q      <= in_map;
			row_q      <= in_row;
			col_q      <= in_col;
			pred_q     <= in_pred;
		end
		if (state_q == bhg_pkg::ST_SSAVE) begin
			sc_q[cidx_q] <= scaled;
		end
	end

	// box store: one write port, one registered read port
	assign wr_box = '{xmin: sc_q[0], ymin: sc_q[1], xmax: sc_q[2], ymax: sc_q[3],
		label: label_q, neg: neg_q};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[count_q[IW-1:0]] <= wr_box;
		end
		rd_q <= mem_q[scan_q[IW-1:0]];
	end

	// gradient select and saturation
	assign dec = {pred_q[bhg_pkg::PW-1], pred_q} - bhg_pkg::ONE_Q16;
	assign wq  = prod[bhg_pkg::PRW-1:16];

	always_comb begin
		if (inside_q) begin
			grad = (dec[bhg_pkg::PW] != dec[bhg_pkg::PW-1]) ? bhg_pkg::SAT_MIN
				: dec[bhg_pkg::PW-1:0];
		end else begin
			case (kind_q)
				bhg_pkg::KIND_PASS: grad = pred_q;
				bhg_pkg::KIND_WEIGHT: begin
					if (wq[33:31] == 3'b000 || wq[33:31] == 3'b111) begin
						grad = wq[31:0];
					end else begin
						grad = wq[33] ? bhg_pkg::SAT_MIN : bhg_pkg::SAT_MAX;
					end
				end
				default: grad = '0;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			grad_q    <= grad;
			ovf_out_q <= ovf_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = grad_q;
	assign m_tuser  = ovf_out_q;

endmodule

[hdl/bhg_checker.sv]
// ---------------------------------------------------------------------------
// bhg_checker: port-level checks for box_heatmap_gradient
// Watches the command and result streams and is bound to the top level.
// ---------------------------------------------------------------------------
module bhg_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [1:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [0:0]  m_tuser
);

	// a stalled result beat holds its contents
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
	else $error("result beat changed while stalled");

	// a query occupies the sequencer for at least the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == bhg_pkg::CMD_QUERY |=> !s_tready)
	else $error("command taken right after a query");

	// a new result only appears after the block was busy
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
	else $error("result appeared without a query in progress");

	// a clear finishes in its own cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == bhg_pkg::CMD_CLEAR |=> s_tready)
	else $error("clear left the block busy");

endmodule

bind box_heatmap_gradient bhg_checker u_bhg_checker (.*);
